// ----- src/dat_pkg.sv -----
// Shared types, codes and constants for the debug argument tokenizer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package dat_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int REG_COUNT       = 16;
    localparam int REG_IDX_W       = 4;
    localparam int REG_W           = 32;
    localparam int TOKEN_W         = 32;

    localparam logic [1:0] OPC_CHAR  = 2'd0;
    localparam logic [1:0] OPC_EOL   = 2'd1;
    localparam logic [1:0] OPC_WRITE = 2'd2;

    localparam logic [1:0] KIND_NUMBER = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_F = 8'h46;
    localparam logic [7:0] CHR_UPPER_X = 8'h58;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_C = 8'h63;
    localparam logic [7:0] CHR_LOWER_F = 8'h66;
    localparam logic [7:0] CHR_LOWER_L = 8'h6c;
    localparam logic [7:0] CHR_LOWER_P = 8'h70;
    localparam logic [7:0] CHR_LOWER_R = 8'h72;
    localparam logic [7:0] CHR_LOWER_S = 8'h73;
    localparam logic [7:0] CHR_LOWER_X = 8'h78;

    localparam logic [3:0] REG_SP  = 4'd13;
    localparam logic [3:0] REG_LR  = 4'd14;
    localparam logic [3:0] REG_PC  = 4'd15;
    localparam logic [3:0] REG_ONE = 4'd1;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_EOL,
        CMD_WRITE
    } cmd_kind_t;

    typedef enum logic [2:0] {
        LT_NONE,
        LT_R,
        LT_P,
        LT_S,
        LT_L,
        LT_C,
        LT_X,
        LT_DOLLAR
    } letter_t;

    typedef struct packed {
        logic       is_space;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;
        letter_t    letter;
    } char_class_t;

    typedef struct packed {
        cmd_kind_t              kind;
        char_class_t            cls;
        logic [REG_IDX_W-1:0]   reg_index;
        logic [REG_W-1:0]       reg_value;
    } item_t;

    typedef enum logic [3:0] {
        ST_ROOT,
        ST_REG,
        ST_REG2,
        ST_LR,
        ST_PC,
        ST_SP,
        ST_DEC,
        ST_HEX,
        ST_PREFIX,
        ST_SUFFIX
    } lex_state_t;

endpackage

`default_nettype wire

// ----- src/dat_cmd_if.sv -----
// Input channel of the tokenizer: characters, end of line, register writes.
// Depends on dat_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dat_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [7:0]                    char_code;
    logic [dat_pkg::REG_IDX_W-1:0] reg_index;
    logic [dat_pkg::REG_W-1:0]     reg_value;

    modport source (output valid, output opcode, output char_code, output reg_index,
                    output reg_value, input ready);
    modport sink   (input valid, input opcode, input char_code, input reg_index,
                    input reg_value, output ready);
endinterface

`default_nettype wire

// ----- src/dat_tok_if.sv -----
// Result channel of the tokenizer: at most one token per item.
// Depends on dat_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dat_tok_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  token_kind;
    logic [dat_pkg::TOKEN_W-1:0] token_value;
    logic                        last_of_line;

    modport source (output valid, output token_kind, output token_value,
                    output last_of_line, input ready);
    modport sink   (input valid, input token_kind, input token_value,
                    input last_of_line, output ready);
endinterface

`default_nettype wire

// ----- src/debug_argument_tokenizer.sv -----
// Top level of the debug argument tokenizer: front end, item queue, lexer back end.
// Depends on dat_pkg, dat_cmd_if, dat_tok_if, dat_front, dat_queue and dat_back.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one item per clock cycle on cmd while the queue is not full, and gives at most
// one token per item on tok. Characters are classified as they are accepted and wait in a
// short queue; the lexer takes one item per cycle from it unless tok is stalled, so the
// sustained rate is one item per cycle, set by the lexer update (one shift-add on the
// accumulator). A closing item is written into the queue, popped by the lexer, and its
// token registered in the result register that drives tok. Register writes and characters
// inside a token give no token. A stalled tok backs up into the queue; cmd.ready drops only when the queue is full.
module debug_argument_tokenizer #(
    parameter int VALUE_WIDTH = dat_pkg::VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = dat_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dat_cmd_if.sink   cmd,
    dat_tok_if.source tok
);

    logic           push_valid, push_ready;
    dat_pkg::item_t push_item;
    logic           pop_valid, pop_ready;
    dat_pkg::item_t pop_item;

    dat_front u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    dat_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dat_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .tok       (tok)
    );

endmodule

`default_nettype wire

// ----- src/dat_front.sv -----
// Front end: accepts input items and classifies characters for the lexer.
// Depends on dat_pkg and dat_cmd_if.
`timescale 1ns / 1ps
`default_nettype none

module dat_front (
    dat_cmd_if.sink        cmd,
    output logic           push_valid,
    input  logic           push_ready,
    output dat_pkg::item_t push_item
);

    dat_pkg::char_class_t cls;
    logic [7:0]           c;

    assign c = cmd.char_code;

    always_comb
    begin
        cls.is_space = (c == dat_pkg::CHR_SPACE);
        cls.is_dec   = (c >= dat_pkg::CHR_ZERO) && (c <= dat_pkg::CHR_NINE);
        cls.is_hex   = 1'b0;
        cls.digit    = c[3:0];
        cls.letter   = dat_pkg::LT_NONE;
        priority if (cls.is_dec)
        begin
            cls.is_hex = 1'b1;
        end
        else if ((c >= dat_pkg::CHR_LOWER_A) && (c <= dat_pkg::CHR_LOWER_F))
        begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(c - dat_pkg::CHR_LOWER_A + 8'd10);
        end
        else if ((c >= dat_pkg::CHR_UPPER_A) && (c <= dat_pkg::CHR_UPPER_F))
        begin
            cls.is_hex = 1'b1;
            cls.digit  = 4'(c - dat_pkg::CHR_UPPER_A + 8'd10);
        end
        else
        begin
            cls.is_hex = 1'b0;
        end

        priority if (c == dat_pkg::CHR_LOWER_R)
            cls.letter = dat_pkg::LT_R;
        else if (c == dat_pkg::CHR_LOWER_P)
            cls.letter = dat_pkg::LT_P;
        else if (c == dat_pkg::CHR_LOWER_S)
            cls.letter = dat_pkg::LT_S;
        else if (c == dat_pkg::CHR_LOWER_L)
            cls.letter = dat_pkg::LT_L;
        else if (c == dat_pkg::CHR_LOWER_C)
            cls.letter = dat_pkg::LT_C;
        else if ((c == dat_pkg::CHR_LOWER_X) || (c == dat_pkg::CHR_UPPER_X))
            cls.letter = dat_pkg::LT_X;
        else if (c == dat_pkg::CHR_DOLLAR)
            cls.letter = dat_pkg::LT_DOLLAR;
        else
            cls.letter = dat_pkg::LT_NONE;
    end

    always_comb
    begin
        push_item.cls       = cls;
        push_item.reg_index = cmd.reg_index;
        push_item.reg_value = cmd.reg_value;
        push_item.kind      = dat_pkg::CMD_CHAR;
        push_valid          = 1'b0;
        unique case (cmd.opcode)
            dat_pkg::OPC_CHAR:
            begin
                push_item.kind = dat_pkg::CMD_CHAR;
                push_valid     = cmd.valid;
            end
            dat_pkg::OPC_EOL:
            begin
                push_item.kind = dat_pkg::CMD_EOL;
                push_valid     = cmd.valid;
            end
            dat_pkg::OPC_WRITE:
            begin
                push_item.kind = dat_pkg::CMD_WRITE;
                push_valid     = cmd.valid;
            end
            default:
            begin
                // unused opcode: taken and dropped
                push_valid = 1'b0;
            end
        endcase
    end

    assign cmd.ready = push_ready;

endmodule

`default_nettype wire

// ----- src/dat_queue.sv -----
// Short FIFO of classified items between the front end and the lexer.
// Depends on dat_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module dat_queue #(
    parameter int QUEUE_DEPTH = dat_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  dat_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output dat_pkg::item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    dat_pkg::item_t   data_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = data_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            data_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ----- src/dat_back.sv -----
// Back end: lexer state machine, shadow register file and result register.
// Depends on dat_pkg and dat_tok_if.
`timescale 1ns / 1ps
`default_nettype none

module dat_back #(
    parameter int VALUE_WIDTH = dat_pkg::VALUE_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  dat_pkg::item_t pop_item,
    dat_tok_if.source      tok
);

    dat_pkg::lex_state_t           state_reg, state_next;
    logic [VALUE_WIDTH-1:0]        acc_reg, acc_next;
    logic                          started_reg, started_next;
    logic                          discard_reg, discard_next;
    logic [dat_pkg::REG_W-1:0]     rf_reg [dat_pkg::REG_COUNT];
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    kind_reg;
    logic [dat_pkg::TOKEN_W-1:0]   value_reg;
    logic                          last_reg;

    logic                          pop;
    logic                          emit;
    logic [1:0]                    emit_kind;
    logic [dat_pkg::TOKEN_W-1:0]   emit_value;
    logic                          emit_last;
    logic                          rf_we;
    logic [dat_pkg::REG_IDX_W-1:0] rd_addr;
    logic [dat_pkg::REG_W-1:0]     rf_rdata;
    logic [dat_pkg::TOKEN_W-1:0]   tok_val;
    logic [VALUE_WIDTH-1:0]        digit_ext;
    logic [VALUE_WIDTH-1:0]        dec_sum;
    logic [VALUE_WIDTH-1:0]        hex_sum;
    dat_pkg::char_class_t          cls;
    logic                          ok;
    dat_pkg::lex_state_t           take_state;
    logic [VALUE_WIDTH-1:0]        take_acc;

    assign cls       = pop_item.cls;
    assign pop       = pop_valid && (!out_valid_reg || tok.ready);
    assign pop_ready = !out_valid_reg || tok.ready;

    always_comb
    begin
        unique case (state_reg)
            dat_pkg::ST_LR:   rd_addr = dat_pkg::REG_LR;
            dat_pkg::ST_PC:   rd_addr = dat_pkg::REG_PC;
            dat_pkg::ST_SP:   rd_addr = dat_pkg::REG_SP;
            dat_pkg::ST_REG2: rd_addr = cls.digit + 4'd10;
            default:          rd_addr = cls.digit;
        endcase
    end

    assign rf_rdata  = rf_reg[rd_addr];
    assign tok_val   = (state_reg == dat_pkg::ST_REG2) ? rf_reg[dat_pkg::REG_ONE]
                                                       : dat_pkg::TOKEN_W'(acc_reg);
    assign digit_ext = VALUE_WIDTH'(cls.digit);
    assign dec_sum   = (acc_reg << 3) + (acc_reg << 1) + digit_ext;
    assign hex_sum   = (acc_reg << 4) + digit_ext;

    // one character step of the lexer
    always_comb
    begin
        ok         = 1'b0;
        take_state = state_reg;
        take_acc   = acc_reg;
        unique case (state_reg)
            dat_pkg::ST_ROOT:
            begin
                ok = 1'b1;
                priority if (cls.letter == dat_pkg::LT_R)
                    take_state = dat_pkg::ST_REG;
                else if (cls.letter == dat_pkg::LT_P)
                    take_state = dat_pkg::ST_PC;
                else if (cls.letter == dat_pkg::LT_S)
                    take_state = dat_pkg::ST_SP;
                else if (cls.letter == dat_pkg::LT_L)
                    take_state = dat_pkg::ST_LR;
                else if (cls.letter == dat_pkg::LT_DOLLAR)
                begin
                    take_state = dat_pkg::ST_HEX;
                    take_acc   = '0;
                end
                else if (cls.is_dec && (cls.digit == 4'd0))
                    take_state = dat_pkg::ST_PREFIX;
                else if (cls.is_dec)
                begin
                    take_state = dat_pkg::ST_DEC;
                    take_acc   = digit_ext;
                end
                else
                    ok = 1'b0;
            end
            dat_pkg::ST_LR, dat_pkg::ST_PC, dat_pkg::ST_SP:
            begin
                ok = ((state_reg == dat_pkg::ST_LR) && (cls.letter == dat_pkg::LT_R))
                  || ((state_reg == dat_pkg::ST_PC) && (cls.letter == dat_pkg::LT_C))
                  || ((state_reg == dat_pkg::ST_SP) && (cls.letter == dat_pkg::LT_P));
                take_acc   = VALUE_WIDTH'(rf_rdata);
                take_state = dat_pkg::ST_SUFFIX;
            end
            dat_pkg::ST_REG:
            begin
                ok = cls.is_dec;
                if (cls.digit == 4'd1)
                    take_state = dat_pkg::ST_REG2;
                else
                begin
                    take_acc   = VALUE_WIDTH'(rf_rdata);
                    take_state = dat_pkg::ST_SUFFIX;
                end
            end
            dat_pkg::ST_REG2:
            begin
                ok         = cls.is_dec && (cls.digit <= 4'd5);
                take_acc   = VALUE_WIDTH'(rf_rdata);
                take_state = dat_pkg::ST_SUFFIX;
            end
            dat_pkg::ST_DEC:
            begin
                ok       = cls.is_dec;
                take_acc = dec_sum;
            end
            dat_pkg::ST_HEX:
            begin
                ok       = cls.is_hex;
                take_acc = hex_sum;
            end
            dat_pkg::ST_PREFIX:
            begin
                ok         = (cls.letter == dat_pkg::LT_X);
                take_acc   = '0;
                take_state = dat_pkg::ST_HEX;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        started_next   = started_reg;
        discard_next   = discard_reg;
        rf_we          = 1'b0;
        emit           = 1'b0;
        emit_kind      = dat_pkg::KIND_NUMBER;
        emit_value     = '0;
        emit_last      = 1'b1;
        out_valid_next = out_valid_reg && !tok.ready;
        if (pop)
        begin
            unique case (pop_item.kind)
                dat_pkg::CMD_WRITE:
                begin
                    rf_we = 1'b1;
                end
                dat_pkg::CMD_EOL:
                begin
                    state_next   = dat_pkg::ST_ROOT;
                    acc_next     = '0;
                    started_next = 1'b0;
                    discard_next = 1'b0;
                    emit         = !discard_reg;
                    emit_kind    = started_reg ? dat_pkg::KIND_NUMBER : dat_pkg::KIND_END;
                    emit_value   = started_reg ? tok_val : '0;
                end
                default:
                begin
                    if (!discard_reg)
                    begin
                        emit = cls.is_space || !ok;
                        if (cls.is_space)
                        begin
                            state_next   = dat_pkg::ST_ROOT;
                            acc_next     = '0;
                            started_next = 1'b0;
                            emit_value   = tok_val;
                            emit_last    = 1'b0;
                        end
                        else if (!ok)
                        begin
                            state_next   = dat_pkg::ST_ROOT;
                            acc_next     = '0;
                            started_next = 1'b0;
                            discard_next = 1'b1;
                            emit_kind    = dat_pkg::KIND_ERROR;
                        end
                        else
                        begin
                            state_next   = take_state;
                            acc_next     = take_acc;
                            started_next = 1'b1;
                        end
                    end
                end
            endcase
        end
        if (emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dat_pkg::ST_ROOT;
            acc_reg       <= '0;
            started_reg   <= 1'b0;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < dat_pkg::REG_COUNT; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            started_reg   <= started_next;
            discard_reg   <= discard_next;
            out_valid_reg <= out_valid_next;
            if (rf_we)
                rf_reg[pop_item.reg_index] <= pop_item.reg_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= emit_kind;
            value_reg <= emit_value;
            last_reg  <= emit_last;
        end
    end

    assign tok.valid        = out_valid_reg;
    assign tok.token_kind   = kind_reg;
    assign tok.token_value  = value_reg;
    assign tok.last_of_line = last_reg;

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == dat_pkg::KIND_ERROR)) |-> (last_reg && (value_reg == '0)))
        else $error("error token must be last of line with zero value");

    a_err_discards: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (emit_kind == dat_pkg::KIND_ERROR)) |=> discard_reg)
        else $error("line not discarded after error");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> !$rose(out_valid_reg))
        else $error("result appeared without an item");

    a_reg2_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != dat_pkg::ST_ROOT) |-> (started_reg && !discard_reg))
        else $error("lexer inside a token that was never started");

endmodule

`default_nettype wire

// ----- verif/tb_debug_argument_tokenizer.sv -----
// Self-checking testbench for debug_argument_tokenizer: directed table, then random lines.
// Depends on dat_pkg, dat_cmd_if, dat_tok_if and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_debug_argument_tokenizer;

    localparam logic [1:0] OPC_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1600;
    localparam int         HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        closes_line;
    } token_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [3:0]  idx;
        logic [31:0] val;
        bit          typed;
        bit          gives;
        token_t      tok;
    } stim_row_t;

    logic clk;
    logic rst_n;

    dat_cmd_if cmd ();
    dat_tok_if tok ();

    debug_argument_tokenizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .tok   (tok)
    );

    // lexer mirror
    dat_pkg::lex_state_t lex_st     = dat_pkg::ST_ROOT;
    logic [31:0]         acc_value  = '0;
    bit                  in_token   = 1'b0;
    bit                  skip_line  = 1'b0;
    logic [31:0]         shadow_regs [dat_pkg::REG_COUNT];

    token_t      pending_tokens [$];
    stim_row_t   directed_rows [$];
    int          items_sent    = 0;
    int          items_taken   = 0;
    int          error_count   = 0;
    int          send_idle_pct = 21;
    int          recv_idle_pct = 55;
    bit          hold_req      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("tb_debug_argument_tokenizer failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        error_count++;
        $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, exp_val);
    endtask

    task automatic tokenize_step(input logic [1:0] op, input logic [7:0] c,
                                 input logic [3:0] idx, input logic [31:0] val,
                                 output bit gives, output token_t t);
        logic [31:0] v;
        logic [7:0]  dv;
        logic [3:0]  hv;
        bit          ok;
        bit          is_dec;
        gives  = 1'b0;
        t      = '0;
        hv     = '0;
        v      = (lex_st == dat_pkg::ST_REG2) ? shadow_regs[dat_pkg::REG_ONE] : acc_value;
        dv     = c - dat_pkg::CHR_ZERO;
        is_dec = (c >= dat_pkg::CHR_ZERO) && (c <= dat_pkg::CHR_NINE);
        case (op)
            dat_pkg::OPC_WRITE: shadow_regs[idx] = val;
            dat_pkg::OPC_EOL:
            begin
                gives         = !skip_line;
                t.kind        = in_token ? dat_pkg::KIND_NUMBER : dat_pkg::KIND_END;
                t.value       = in_token ? v : '0;
                t.closes_line = 1'b1;
                lex_st        = dat_pkg::ST_ROOT;
                acc_value     = '0;
                in_token      = 1'b0;
                skip_line     = 1'b0;
            end
            dat_pkg::OPC_CHAR:
            begin
                if (!skip_line && c == dat_pkg::CHR_SPACE)
                begin
                    gives     = 1'b1;
                    t.kind    = dat_pkg::KIND_NUMBER;
                    t.value   = v;
                    lex_st    = dat_pkg::ST_ROOT;
                    acc_value = '0;
                    in_token  = 1'b0;
                end
                else if (!skip_line)
                begin
                    in_token = 1'b1;
                    ok       = 1'b1;
                    case (lex_st)
                        dat_pkg::ST_ROOT:
                        begin
                            if (c == dat_pkg::CHR_LOWER_R)
                                lex_st = dat_pkg::ST_REG;
                            else if (c == dat_pkg::CHR_LOWER_P)
                                lex_st = dat_pkg::ST_PC;
                            else if (c == dat_pkg::CHR_LOWER_S)
                                lex_st = dat_pkg::ST_SP;
                            else if (c == dat_pkg::CHR_LOWER_L)
                                lex_st = dat_pkg::ST_LR;
                            else if (c == dat_pkg::CHR_DOLLAR)
                            begin
                                lex_st    = dat_pkg::ST_HEX;
                                acc_value = '0;
                            end
                            else if (c == dat_pkg::CHR_ZERO)
                                lex_st = dat_pkg::ST_PREFIX;
                            else if (is_dec)
                            begin
                                lex_st    = dat_pkg::ST_DEC;
                                acc_value = 32'(dv);
                            end
                            else
                                ok = 1'b0;
                        end
                        dat_pkg::ST_LR:
                        begin
                            ok = (c == dat_pkg::CHR_LOWER_R);
                            acc_value = shadow_regs[dat_pkg::REG_LR];
                            lex_st    = dat_pkg::ST_SUFFIX;
                        end
                        dat_pkg::ST_PC:
                        begin
                            ok = (c == dat_pkg::CHR_LOWER_C);
                            acc_value = shadow_regs[dat_pkg::REG_PC];
                            lex_st    = dat_pkg::ST_SUFFIX;
                        end
                        dat_pkg::ST_SP:
                        begin
                            ok = (c == dat_pkg::CHR_LOWER_P);
                            acc_value = shadow_regs[dat_pkg::REG_SP];
                            lex_st    = dat_pkg::ST_SUFFIX;
                        end
                        dat_pkg::ST_REG:
                        begin
                            if (!is_dec)
                                ok = 1'b0;
                            else if (dv == 8'd1)
                                lex_st = dat_pkg::ST_REG2;
                            else
                            begin
                                acc_value = shadow_regs[dv[3:0]];
                                lex_st    = dat_pkg::ST_SUFFIX;
                            end
                        end
                        dat_pkg::ST_REG2:
                        begin
                            ok = is_dec && (dv <= 8'd5);
                            acc_value = shadow_regs[dv[3:0] + 4'd10];
                            lex_st    = dat_pkg::ST_SUFFIX;
                        end
                        dat_pkg::ST_DEC:
                        begin
                            ok = is_dec;
                            acc_value = acc_value * 32'd10 + 32'(dv);
                        end
                        dat_pkg::ST_HEX:
                        begin
                            if (is_dec)
                                hv = dv[3:0];
                            else if (c >= dat_pkg::CHR_LOWER_A && c <= dat_pkg::CHR_LOWER_F)
                                hv = 4'(c - dat_pkg::CHR_LOWER_A + 8'd10);
                            else if (c >= dat_pkg::CHR_UPPER_A && c <= dat_pkg::CHR_UPPER_F)
                                hv = 4'(c - dat_pkg::CHR_UPPER_A + 8'd10);
                            else
                                ok = 1'b0;
                            acc_value = {acc_value[27:0], hv};
                        end
                        dat_pkg::ST_PREFIX:
                        begin
                            ok = (c == dat_pkg::CHR_LOWER_X) || (c == dat_pkg::CHR_UPPER_X);
                            acc_value = '0;
                            lex_st    = dat_pkg::ST_HEX;
                        end
                        default: ok = 1'b0;
                    endcase
                    if (!ok)
                    begin
                        lex_st        = dat_pkg::ST_ROOT;
                        acc_value     = '0;
                        in_token      = 1'b0;
                        skip_line     = 1'b1;
                        gives         = 1'b1;
                        t.kind        = dat_pkg::KIND_ERROR;
                        t.value       = '0;
                        t.closes_line = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin : token_monitor
        token_t exp_tok;
        bit     gives;
        if (rst_n)
        begin
            if (tok.valid && tok.ready)
            begin
                if (pending_tokens.size() == 0)
                    report_mismatch("token with none pending", tok.token_value, '0);
                else
                begin
                    exp_tok = pending_tokens.pop_front();
                    if (tok.token_kind !== exp_tok.kind)
                        report_mismatch("token_kind", 32'(tok.token_kind),
                                        32'(exp_tok.kind));
                    if (tok.token_value !== exp_tok.value)
                        report_mismatch("token_value", tok.token_value, exp_tok.value);
                    if (tok.last_of_line !== exp_tok.closes_line)
                        report_mismatch("last_of_line", 32'(tok.last_of_line),
                                        32'(exp_tok.closes_line));
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                tokenize_step(cmd.opcode, cmd.char_code, cmd.reg_index, cmd.reg_value,
                              gives, exp_tok);
                if (items_taken < directed_rows.size() && directed_rows[items_taken].typed)
                begin
                    gives   = directed_rows[items_taken].gives;
                    exp_tok = directed_rows[items_taken].tok;
                end
                if (gives)
                    pending_tokens.push_back(exp_tok);
                items_taken++;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin : tok_receiver
        int hold_left;
        hold_left = 0;
        tok.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tok.ready <= 1'b0;
            end
            else
                tok.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [3:0] idx, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.opcode    <= op;
        cmd.char_code <= ch;
        cmd.reg_index <= idx;
        cmd.reg_value <= val;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // register writes and stray opcodes fall between characters; some characters are corrupted
    task automatic send_char(input logic [7:0] c);
        if ($urandom_range(99) < 4)
            send_item(dat_pkg::OPC_WRITE, 8'($urandom), 4'($urandom),
                      ($urandom_range(3) == 0) ? 32'h0 :
                      ($urandom_range(2) == 0) ? 32'hFFFF_FFFF : $urandom);
        if ($urandom_range(199) == 0)
            send_item(OPC_UNUSED, 8'($urandom), 4'($urandom), $urandom);
        if ($urandom_range(99) < 3)
            c = 8'($urandom_range(255));
        send_item(dat_pkg::OPC_CHAR, c, 4'($urandom), $urandom);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
        if (d < 4'd10)
            return dat_pkg::CHR_ZERO + d;
        return (upper ? dat_pkg::CHR_UPPER_A : dat_pkg::CHR_LOWER_A) + d - 8'd10;
    endfunction

    task automatic send_token();
        int n;
        case ($urandom_range(7))
            0:
            begin
                send_char(dat_pkg::CHR_ZERO + 8'($urandom_range(9, 1)));
                repeat ($urandom_range(12))
                    send_char(dat_pkg::CHR_ZERO + 8'($urandom_range(9)));
            end
            1:
            begin
                send_char(dat_pkg::CHR_DOLLAR);
                repeat ($urandom_range(10))
                    send_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
            2:
            begin
                send_char(dat_pkg::CHR_ZERO);
                send_char($urandom_range(1) ? dat_pkg::CHR_LOWER_X : dat_pkg::CHR_UPPER_X);
                repeat ($urandom_range(10))
                    send_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            end
            3: send_char(dat_pkg::CHR_ZERO);
            4, 5:
            begin
                n = $urandom_range(15);
                send_char(dat_pkg::CHR_LOWER_R);
                if (n >= 10)
                begin
                    send_char(dat_pkg::CHR_ZERO + 8'd1);
                    send_char(dat_pkg::CHR_ZERO + 8'(n - 10));
                end
                else
                    send_char(dat_pkg::CHR_ZERO + 8'(n));
            end
            6:
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        send_char(dat_pkg::CHR_LOWER_S);
                        send_char(dat_pkg::CHR_LOWER_P);
                    end
                    1:
                    begin
                        send_char(dat_pkg::CHR_LOWER_L);
                        send_char(dat_pkg::CHR_LOWER_R);
                    end
                    2:
                    begin
                        send_char(dat_pkg::CHR_LOWER_P);
                        send_char(dat_pkg::CHR_LOWER_C);
                    end
                    default:
                    begin
                        n = $urandom_range(3);
                        send_char(n == 0 ? dat_pkg::CHR_LOWER_R :
                                  n == 1 ? dat_pkg::CHR_LOWER_S :
                                  n == 2 ? dat_pkg::CHR_LOWER_L : dat_pkg::CHR_LOWER_P);
                    end
                endcase
            end
            default: ;
        endcase
    endtask

    task automatic send_line();
        int n_tok;
        n_tok = $urandom_range(4);
        if ($urandom_range(9) == 0)
            send_char(dat_pkg::CHR_SPACE);
        for (int i = 0; i < n_tok; i++)
        begin
            if (i > 0)
                send_char(dat_pkg::CHR_SPACE);
            send_token();
        end
        if ($urandom_range(9) == 0)
            send_char(dat_pkg::CHR_SPACE);
        send_item(dat_pkg::OPC_EOL, 8'($urandom), 4'($urandom), $urandom);
    endtask

    function automatic void add_row(input logic [1:0] op, input logic [7:0] ch,
                                    input logic [3:0] idx, input logic [31:0] val,
                                    input bit typed, input bit gives, input logic [1:0] kind,
                                    input logic [31:0] value, input logic closes_line);
        stim_row_t row;
        row.op      = op;
        row.ch      = ch;
        row.idx     = idx;
        row.val     = val;
        row.typed   = typed;
        row.gives   = gives;
        row.tok     = '{kind: kind, value: value, closes_line: closes_line};
        directed_rows.push_back(row);
    endfunction

    initial
    begin : stimulus
        int base;
        rst_n         <= 1'b0;
        cmd.valid     <= 1'b0;
        cmd.opcode    <= dat_pkg::OPC_CHAR;
        cmd.char_code <= '0;
        cmd.reg_index <= '0;
        cmd.reg_value <= '0;
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;

        //       op                  char                  idx      value
        //       typ gv kind value last
        add_row(dat_pkg::OPC_EOL,   '0, '0, '0,
                1'b1, 1'b1, dat_pkg::KIND_END, '0, 1'b1);
        add_row(dat_pkg::OPC_WRITE, '0, dat_pkg::REG_ONE, 32'hFFFF_FFFF,
                1'b1, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_WRITE, '0, dat_pkg::REG_PC, 32'hA5A5_5A5A,
                1'b1, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        // lone r1 names register 1
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_LOWER_R, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  "1", '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_SPACE, '0, '0,
                1'b1, 1'b1, dat_pkg::KIND_NUMBER, 32'hFFFF_FFFF, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_LOWER_R, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  "1", '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  "5", '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_EOL,   '0, '0, '0,
                1'b1, 1'b1, dat_pkg::KIND_NUMBER, 32'hA5A5_5A5A, 1'b1);
        // leading space gives an empty token
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_SPACE, '0, '0,
                1'b1, 1'b1, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_DOLLAR, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_LOWER_F, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_UPPER_F, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_SPACE, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        // bare 0x prefix
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_ZERO, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_LOWER_X, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_EOL,   '0, '0, '0,
                1'b1, 1'b1, dat_pkg::KIND_NUMBER, '0, 1'b1);
        // trailing character after a register name, then a discarded line
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_LOWER_P, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_LOWER_C, '0, '0,
                1'b0, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_LOWER_X, '0, '0,
                1'b1, 1'b1, dat_pkg::KIND_ERROR, '0, 1'b1);
        add_row(dat_pkg::OPC_CHAR,  dat_pkg::CHR_SPACE, '0, '0,
                1'b1, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_EOL,   '0, '0, '0,
                1'b1, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_CHAR,  8'h00, '0, '0,
                1'b1, 1'b1, dat_pkg::KIND_ERROR, '0, 1'b1);
        add_row(dat_pkg::OPC_CHAR,  8'hFF, '0, '0,
                1'b1, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(dat_pkg::OPC_EOL,   '0, '0, '0,
                1'b1, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);
        add_row(OPC_UNUSED,         8'hFF, 4'hF, 32'hFFFF_FFFF,
                1'b1, 1'b0, dat_pkg::KIND_NUMBER, '0, 1'b0);

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].ch,
                      directed_rows[i].idx, directed_rows[i].val);

        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS)
        begin
            if (items_sent >= base + 2 * RANDOM_ITEMS / 3)
            begin
                if (send_idle_pct != 0 || recv_idle_pct != 0)
                    hold_req = 1'b1;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (items_sent >= base + RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 21;
            end
            send_line();
        end
        cmd.valid <= 1'b0;

        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (error_count == 0 && pending_tokens.size() == 0)
            $display("tb_debug_argument_tokenizer passed");
        else
            $display("tb_debug_argument_tokenizer failed");
        $finish;
    end

endmodule
